// ===== src/wsd_pkg.sv =====
package wsd_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [2:0] PH_BYTE0   = 3'd0;
	localparam logic [2:0] PH_BYTE1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_HALT    = 3'd5;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic [3:0] message_opcode;
		logic       fin_flag;
		logic       is_control;
		logic       last_of_frame;
	} res_t;

endpackage

// ===== src/wsd_parser.sv =====
module wsd_parser #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    data,
	output logic          res_valid,
	output wsd_pkg::res_t res
);

	logic [2:0]             phase_q, phase_d;
	logic [3:0]             count_q, count_d;
	logic [3:0]             opcode_q, opcode_d;
	logic                   fin_q, fin_d;
	logic [6:0]             short_len_q, short_len_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             index_q, index_d;
	logic [3:0]             stored_q, stored_d;

	logic [3:0]             count_inc;
	logic [LENGTH_BITS-1:0] remain_shift;
	logic [LENGTH_BITS-1:0] remain_dec;
	logic [7:0]             key_byte;
	logic [3:0]             ext_bytes;

	assign count_inc    = count_q + 4'd1;
	assign remain_shift = {remain_q[LENGTH_BITS-9:0], data};
	assign remain_dec   = remain_q - LENGTH_BITS'(1);
	assign key_byte     = key_q[{~index_q, 3'b000} +: 8];
	assign ext_bytes    = (short_len_q == wsd_pkg::LEN_EXT16) ?
		wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		opcode_d    = opcode_q;
		fin_d       = fin_q;
		short_len_d = short_len_q;
		remain_d    = remain_q;
		key_d       = key_q;
		index_d     = index_q;
		stored_d    = stored_q;
		res_valid   = 1'b0;
		res.kind           = wsd_pkg::KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.frame_opcode   = opcode_q;
		res.message_opcode = (opcode_q == 4'd0) ? stored_q : opcode_q;
		res.fin_flag       = fin_q;
		res.is_control     = opcode_q[3];
		res.last_of_frame  = 1'b1;
		if (fire) begin
			unique case (phase_q)
				wsd_pkg::PH_BYTE0: begin
					opcode_d = data[3:0];
					fin_d    = data[7];
					phase_d  = wsd_pkg::PH_BYTE1;
				end
				wsd_pkg::PH_BYTE1: begin
					if (!data[7]) begin
						phase_d   = wsd_pkg::PH_HALT;
						res_valid = 1'b1;
						res.kind  = wsd_pkg::KIND_ERROR;
					end else begin
						short_len_d = data[6:0];
						count_d     = 4'd0;
						key_d       = 32'd0;
						if (data[6:0] == wsd_pkg::LEN_EXT16 ||
						    data[6:0] == wsd_pkg::LEN_EXT64) begin
							remain_d = '0;
							phase_d  = wsd_pkg::PH_EXTLEN;
						end else begin
							remain_d = {{(LENGTH_BITS-7){1'b0}}, data[6:0]};
							phase_d  = wsd_pkg::PH_MASK;
						end
					end
				end
				wsd_pkg::PH_EXTLEN: begin
					remain_d = remain_shift;
					count_d  = count_inc;
					if (count_inc >= ext_bytes) begin
						count_d = 4'd0;
						phase_d = wsd_pkg::PH_MASK;
					end
				end
				wsd_pkg::PH_MASK: begin
					key_d   = {key_q[23:0], data};
					count_d = count_inc;
					if (count_inc >= wsd_pkg::KEY_BYTES) begin
						if (opcode_q != 4'd0 && !opcode_q[3] && !fin_q)
							stored_d = opcode_q;
						index_d = 2'd0;
						count_d = 4'd0;
						if (remain_q == '0) begin
							phase_d   = wsd_pkg::PH_BYTE0;
							res_valid = 1'b1;
							res.kind  = wsd_pkg::KIND_EMPTY;
						end else begin
							phase_d = wsd_pkg::PH_PAYLOAD;
						end
					end
				end
				wsd_pkg::PH_PAYLOAD: begin
					index_d          = index_q + 2'd1;
					remain_d         = remain_dec;
					res_valid        = 1'b1;
					res.payload_byte = data ^ key_byte;
					res.last_of_frame = (remain_dec == '0);
					if (remain_dec == '0)
						phase_d = wsd_pkg::PH_BYTE0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsd_pkg::PH_BYTE0;
			count_q     <= 4'd0;
			opcode_q    <= 4'd0;
			fin_q       <= 1'b0;
			short_len_q <= 7'd0;
			remain_q    <= '0;
			key_q       <= 32'd0;
			index_q     <= 2'd0;
			stored_q    <= 4'd0;
		end else begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			opcode_q    <= opcode_d;
			fin_q       <= fin_d;
			short_len_q <= short_len_d;
			remain_q    <= remain_d;
			key_q       <= key_d;
			index_q     <= index_d;
			stored_q    <= stored_d;
		end
	end

endmodule

// ===== src/wsd_out_reg.sv =====
module wsd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wsd_pkg::res_t res,
	input  logic          stall,
	output logic          valid,
	output logic          blocked,
	output wsd_pkg::res_t res_q
);

	logic valid_q;

	assign valid   = valid_q;
	assign blocked = valid_q && stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (valid_q && !stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

// ===== src/websocket_frame_deframer.sv =====
// channel | handshake                   | payload
// input   | data_valid / data_stall     | data_byte
// output  | result_valid / result_stall | kind, payload_byte, frame_opcode,
//         |                             | message_opcode, fin_flag, is_control,
//         |                             | last_of_frame
// One byte per cycle sustained while result_stall is low; a byte's result passes the
// input register, then the result register, on its way to the outputs. Header bytes give
// no result, but for the last mask byte of an empty frame and the second byte of an unmasked one.
// A full result register under stall holds the input register, which then stalls input.
// arst_n returns the parser to the first header byte; after an unmasked frame it
// drops every byte until reset.
module websocket_frame_deframer #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic [3:0] message_opcode,
	output logic       fin_flag,
	output logic       is_control,
	output logic       last_of_frame
);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          blocked;
	logic          fire;
	logic          accept;
	logic          res_valid;
	wsd_pkg::res_t res;
	wsd_pkg::res_t res_q;

	assign fire       = valid_s1 && !blocked;
	assign data_stall = valid_s1 && blocked;
	assign accept     = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			data_s1 <= data_byte;
	end

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data      (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && res_valid),
		.res     (res),
		.stall   (result_stall),
		.valid   (result_valid),
		.blocked (blocked),
		.res_q   (res_q)
	);

	assign kind           = res_q.kind;
	assign payload_byte   = res_q.payload_byte;
	assign frame_opcode   = res_q.frame_opcode;
	assign message_opcode = res_q.message_opcode;
	assign fin_flag       = res_q.fin_flag;
	assign is_control     = res_q.is_control;
	assign last_of_frame  = res_q.last_of_frame;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (result_valid && result_stall))
		else $error("input stalled without a blocked result");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != wsd_pkg::KIND_PAYLOAD) |-> last_of_frame)
		else $error("empty or error result not marked last");

	a_control: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_control == frame_opcode[3]))
		else $error("control flag disagrees with opcode");
`endif

endmodule

// ===== tb/websocket_frame_deframer_test.sv =====
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

	localparam int unsigned RANDOM_BYTES = 1650;
	localparam int unsigned QUIET_BYTES  = 200;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned OPENING_ROWS = 28;
	localparam int unsigned CLOSING_ROWS = 6;
	localparam int          LEN_BITS     = wsd_pkg::LENGTH_BITS_DEF;

	typedef struct packed {
		logic [7:0]    data;
		logic          typed;
		wsd_pkg::res_t want;
	} stim_row_t;

	localparam wsd_pkg::res_t NO_RES = '0;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       data_valid   = 1'b0;
	logic       data_stall;
	logic [7:0] data_byte    = 8'h00;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic [3:0] message_opcode;
	logic       fin_flag;
	logic       is_control;
	logic       last_of_frame;

	websocket_frame_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_valid     (data_valid),
		.data_stall     (data_stall),
		.data_byte      (data_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.frame_opcode   (frame_opcode),
		.message_opcode (message_opcode),
		.fin_flag       (fin_flag),
		.is_control     (is_control),
		.last_of_frame  (last_of_frame)
	);

	// ping with empty body, fragmented text with 64-bit length (upper garbage dropped),
	// then its continuation
	stim_row_t opening_rows [OPENING_ROWS] = '{
		'{8'h89, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
		'{8'h12, 1'b0, NO_RES}, '{8'h34, 1'b0, NO_RES}, '{8'h56, 1'b0, NO_RES},
		'{8'h78, 1'b1, '{wsd_pkg::KIND_EMPTY, 8'h00, 4'h9, 4'h9, 1'b1, 1'b1, 1'b1}},
		'{8'h01, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'hA5, 1'b0, NO_RES},
		'{8'h5A, 1'b0, NO_RES}, '{8'h0F, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES}, '{8'h81, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}
	};

	// unmasked pong: error, then the parser drops everything
	stim_row_t closing_rows [CLOSING_ROWS] = '{
		'{8'h8A, 1'b0, NO_RES},
		'{8'h05, 1'b1, '{wsd_pkg::KIND_ERROR, 8'h00, 4'hA, 4'hA, 1'b1, 1'b1, 1'b1}},
		'{8'h81, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}
	};

	// parser state mirror
	logic [2:0]          hdr_phase    = wsd_pkg::PH_BYTE0;
	logic [3:0]          hdr_count    = '0;
	logic [3:0]          frm_op       = '0;
	logic                frm_fin      = 1'b0;
	logic [6:0]          len7         = '0;
	logic [LEN_BITS-1:0] bytes_left   = '0;
	logic [31:0]         key_word     = '0;
	logic [1:0]          key_idx      = '0;
	logic [3:0]          msg_op_saved = '0;

	wsd_pkg::res_t expected_results [$];
	int unsigned fails         = 0;
	int unsigned results_seen  = 0;
	int unsigned bytes_sent    = 0;
	int unsigned frames_sent   = 0;
	int unsigned short_frames  = 0;
	int unsigned ext16_frames  = 0;
	int unsigned ext64_frames  = 0;
	int unsigned cycle_count   = 0;
	bit          tail_quiet    = 1'b0;

	function automatic wsd_pkg::res_t frame_result(logic [1:0] k, logic [7:0] d,
			logic last);
		wsd_pkg::res_t r;
		r.kind           = k;
		r.payload_byte   = d;
		r.frame_opcode   = frm_op;
		r.message_opcode = (frm_op == 4'd0) ? msg_op_saved : frm_op;
		r.fin_flag       = frm_fin;
		r.is_control     = frm_op[3];
		r.last_of_frame  = last;
		return r;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output wsd_pkg::res_t r);
		bit         got;
		logic [7:0] kb;
		logic [3:0] ext_len;
		got = 1'b0;
		r   = '0;
		case (hdr_phase)
			wsd_pkg::PH_BYTE0: begin
				frm_op    = b[3:0];
				frm_fin   = b[7];
				hdr_phase = wsd_pkg::PH_BYTE1;
			end
			wsd_pkg::PH_BYTE1: begin
				if (!b[7]) begin
					hdr_phase = wsd_pkg::PH_HALT;
					r         = frame_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b1);
					got       = 1'b1;
				end else begin
					len7      = b[6:0];
					hdr_count = '0;
					key_word  = '0;
					if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
						bytes_left = '0;
						hdr_phase  = wsd_pkg::PH_EXTLEN;
					end else begin
						bytes_left = LEN_BITS'(len7);
						hdr_phase  = wsd_pkg::PH_MASK;
					end
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				bytes_left = {bytes_left[LEN_BITS-9:0], b};
				hdr_count  = hdr_count + 4'd1;
				ext_len    = (len7 == wsd_pkg::LEN_EXT16) ?
					wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
				if (hdr_count >= ext_len) begin
					hdr_count = '0;
					hdr_phase = wsd_pkg::PH_MASK;
				end
			end
			wsd_pkg::PH_MASK: begin
				key_word  = {key_word[23:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= wsd_pkg::KEY_BYTES) begin
					if (frm_op != 4'd0 && !frm_op[3] && !frm_fin)
						msg_op_saved = frm_op;
					key_idx   = '0;
					hdr_count = '0;
					if (bytes_left == '0) begin
						hdr_phase = wsd_pkg::PH_BYTE0;
						r         = frame_result(wsd_pkg::KIND_EMPTY, 8'h00, 1'b1);
						got       = 1'b1;
					end else begin
						hdr_phase = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				kb         = 8'(key_word >> (8 * (2'd3 - key_idx)));
				key_idx    = key_idx + 2'd1;
				bytes_left = bytes_left - LEN_BITS'(1);
				r          = frame_result(wsd_pkg::KIND_PAYLOAD, b ^ kb, bytes_left == '0);
				got        = 1'b1;
				if (bytes_left == '0)
					hdr_phase = wsd_pkg::PH_BYTE0;
			end
			default: ;
		endcase
		return got;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
			input wsd_pkg::res_t want = '0);
		wsd_pkg::res_t r;
		if (!tail_quiet && $urandom_range(0, 7) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		bytes_sent++;
		if (deframe_byte(b, r))
			expected_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain_results();
		data_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic push_random_frame();
		logic [3:0]  op;
		logic [7:0]  hdr0;
		logic [31:0] key;
		logic [31:0] len;
		int unsigned form;
		op   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 2)) :
			4'($urandom_range(0, 15));
		hdr0 = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op};
		form = $urandom_range(0, 9);
		key  = $urandom;
		push_byte(hdr0);
		if (form < 7) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
			push_byte({1'b1, 7'(len)});
			short_frames++;
		end else if (form < 9) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300) :
				$urandom_range(0, 40);
			push_byte({1'b1, wsd_pkg::LEN_EXT16});
			push_byte(len[15:8]);
			push_byte(len[7:0]);
			ext16_frames++;
		end else begin
			len = $urandom_range(0, 20);
			push_byte({1'b1, wsd_pkg::LEN_EXT64});
			for (int i = 0; i < 4; i++)
				push_byte(8'($urandom));
			for (int i = 3; i >= 0; i--)
				push_byte(len[8*i +: 8]);
			ext64_frames++;
		end
		for (int i = 3; i >= 0; i--)
			push_byte(key[8*i +: 8]);
		for (int unsigned i = 0; i < len; i++)
			push_byte(8'($urandom));
		frames_sent++;
	endtask

	function automatic void check_fields(wsd_pkg::res_t want);
		if (kind !== want.kind) begin
			$error("kind expected %0d got %0d", want.kind, kind);
			fails++;
		end
		if (payload_byte !== want.payload_byte) begin
			$error("payload_byte expected %h got %h", want.payload_byte, payload_byte);
			fails++;
		end
		if (frame_opcode !== want.frame_opcode) begin
			$error("frame_opcode expected %h got %h", want.frame_opcode, frame_opcode);
			fails++;
		end
		if (message_opcode !== want.message_opcode) begin
			$error("message_opcode expected %h got %h", want.message_opcode,
				message_opcode);
			fails++;
		end
		if (fin_flag !== want.fin_flag) begin
			$error("fin_flag expected %b got %b", want.fin_flag, fin_flag);
			fails++;
		end
		if (is_control !== want.is_control) begin
			$error("is_control expected %b got %b", want.is_control, is_control);
			fails++;
		end
		if (last_of_frame !== want.last_of_frame) begin
			$error("last_of_frame expected %b got %b", want.last_of_frame, last_of_frame);
			fails++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("websocket_frame_deframer regression: fail");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (tail_quiet) begin
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20) - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: kind %0d byte %h", kind, payload_byte);
				fails++;
			end else begin
				check_fields(expected_results.pop_front());
			end
		end
	end

	initial begin
		bit mid_drained;
		mid_drained = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i])
			push_byte(opening_rows[i].data, opening_rows[i].typed, opening_rows[i].want);
		drain_results();

		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= RANDOM_BYTES - QUIET_BYTES)
				tail_quiet = 1'b1;
			if (!mid_drained && bytes_sent >= RANDOM_BYTES / 2) begin
				drain_results();
				mid_drained = 1'b1;
			end
			push_random_frame();
		end
		tail_quiet = 1'b1;
		drain_results();

		foreach (closing_rows[i])
			push_byte(closing_rows[i].data, closing_rows[i].typed, closing_rows[i].want);
		data_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("covered %0d bytes in %0d random frames (%0d short, %0d 16-bit, %0d 64-bit len)",
			bytes_sent, frames_sent, short_frames, ext16_frames, ext64_frames);
		$display("checked %0d results, ending with an unmasked frame and halted input",
			results_seen);
		if (fails == 0)
			$display("websocket_frame_deframer regression: pass");
		else
			$display("websocket_frame_deframer regression: fail");
		$finish;
	end

endmodule
